// File: design/heartbeat_producer_consumer_unit_assert.svh
// Assertion macros used by the checker file of the heartbeat unit.
`ifndef HEARTBEAT_PRODUCER_CONSUMER_UNIT_ASSERT_SVH
`define HEARTBEAT_PRODUCER_CONSUMER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPCU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heartbeat unit assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HPCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heartbeat unit assertion failed");

`endif

// File: design/hpcu_pkg.sv
`timescale 1ns / 1ps

package hpcu_pkg;

   // Fixed constants of the heartbeat protocol.
   localparam logic [10:0] HB_BASE_ID       = 11'h700;
   localparam logic [31:0] US_PER_MS        = 32'd1000;
   localparam logic [7:0]  MAX_CHECKED_NODE = 8'd127;
   localparam logic [6:0]  CODE_PREOP       = 7'd127;
   localparam logic [6:0]  CODE_OPER        = 7'd5;
   localparam logic [6:0]  CODE_STOP        = 7'd4;
   localparam logic [6:0]  CODE_NONE        = 7'd0;
   localparam int          MASK_W           = 8;
   localparam int          CSR_ADDR_W       = 3;

   typedef enum logic [1:0] {
      REQ_HEARTBEAT  = 2'd0,
      REQ_TICK       = 2'd1,
      REQ_SLOT_WRITE = 2'd2,
      REQ_SLOT_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      NMT_INIT    = 2'd0,
      NMT_PREOP   = 2'd1,
      NMT_OPER    = 2'd2,
      NMT_STOPPED = 2'd3
   } nmt_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_TICK_INIT = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_PERIOD = 1'b0,
      CSR_OWN_ID = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DRAIN,
      FSM_COMMIT,
      FSM_PRES,
      FSM_DONE
   } fsm_type;

   // One consumer slot as stored in the slot memory.
   typedef struct packed {
      logic [7:0]  node;
      logic [15:0] timeout_ms;
      logic [31:0] last_seen_us;
      logic        alive;
   } slot_type;

   // One accepted request word.
   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   node_id;
      logic [31:0]  now_us;
      nmt_type      nmt;
      logic [7:0]   slot_index;
      logic [23:0]  slot_entry;
   } item_type;

   typedef struct packed {
      logic [15:0] period_ms;
      logic [6:0]  own_id;
   } cfg_type;

   // Status of the slot scan, seen by the sequencer.
   typedef struct packed {
      logic              dup;
      logic              idle;
      logic [MASK_W-1:0] mask;
      logic              err;
      logic [7:0]        capt_node;
      logic [15:0]       capt_timeout;
      logic              clr_valid;
      logic [7:0]        clr_node;
   } slot_stat_type;

   function automatic logic [31:0] ms_to_us(input logic [15:0] ms);
      return 32'(ms) * US_PER_MS;
   endfunction

   function automatic logic [6:0] state_code(input nmt_type nmt);
      logic [6:0] code;
      unique case (nmt)
         NMT_PREOP:   code = CODE_PREOP;
         NMT_OPER:    code = CODE_OPER;
         NMT_STOPPED: code = CODE_STOP;
         NMT_INIT:    code = CODE_NONE;
      endcase
      return code;
   endfunction

endpackage

// File: design/hpcu_ram.sv
`timescale 1ns / 1ps

module hpcu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: design/hpcu_csr.sv
`timescale 1ns / 1ps

module hpcu_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hpcu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output hpcu_pkg::cfg_type               cfg
);

   import hpcu_pkg::*;

   logic [15:0]   period_ff;
   logic [6:0]    own_id_ff;
   logic          wr;
   csr_index_type idx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = csr_index_type'(paddr[2]);

   // Register writes complete in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         own_id_ff <= 7'd1;
      end else if (wr) begin
         unique case (idx)
            CSR_PERIOD: period_ff <= pwdata[15:0];
            CSR_OWN_ID: own_id_ff <= pwdata[6:0];
         endcase
      end
   end

   // Read data follows the address.
   always_comb begin
      unique case (idx)
         CSR_PERIOD: prdata = 32'(period_ff);
         CSR_OWN_ID: prdata = 32'(own_id_ff);
      endcase
   end

   assign cfg.period_ms = period_ff;
   assign cfg.own_id    = own_id_ff;

endmodule

// File: design/hpcu_slot_pipe.sv
`timescale 1ns / 1ps

module hpcu_slot_pipe #(
   parameter int NUM_SLOTS = 8,
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hpcu_pkg::item_type      item,
   input  logic                    start,
   input  logic                    issue,
   input  logic [IW-1:0]           issue_idx,
   input  logic                    commit,
   output hpcu_pkg::slot_stat_type stat
);

   import hpcu_pkg::*;

   localparam int SW = $bits(slot_type);

   logic [NUM_SLOTS-1:0] vld_ff, vld_in;
   logic                 pa_vld_ff;
   logic [IW-1:0]        pa_idx_ff;
   logic                 pb_vld_ff;
   logic [IW-1:0]        pb_idx_ff;
   slot_type             pb_slot_ff;
   logic [31:0]          pb_elapsed_ff;
   logic [31:0]          pb_limit_ff;
   logic [SW-1:0]        q_bits;
   slot_type             pa_slot;
   logic                 dup_ff, dup_in;
   slot_type             capt_ff, capt_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic                 err_ff, err_in;
   logic                 we;
   logic [IW-1:0]        waddr;
   slot_type             wdata;
   logic [7:0]           wr_node;
   logic [15:0]          wr_timeout;
   logic [7:0]           s8;
   logic [7:0]           pb_idx8;
   logic                 hit;
   logic                 expire;
   slot_type             pb_new;

   hpcu_ram #(
      .WIDTH(SW),
      .DEPTH(NUM_SLOTS)
   ) u_slot_ram (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(issue_idx),
      .rdata(q_bits)
   );

   // A slot never written reads as its reset value of zero.
   assign pa_slot = vld_ff[pa_idx_ff] ? slot_type'(q_bits) : '0;

   // Stage A: memory data arrives; elapsed time and limit are registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pa_vld_ff <= 1'b0;
         pb_vld_ff <= 1'b0;
      end else begin
         pa_vld_ff <= issue;
         pb_vld_ff <= pa_vld_ff;
      end
      pa_idx_ff     <= issue_idx;
      pb_idx_ff     <= pa_idx_ff;
      pb_slot_ff    <= pa_slot;
      pb_elapsed_ff <= item.now_us - pa_slot.last_seen_us;
      pb_limit_ff   <= ms_to_us(pa_slot.timeout_ms);
   end

   assign s8         = item.slot_index - 8'd1;
   assign pb_idx8    = 8'(pb_idx_ff);
   assign wr_node    = item.slot_entry[23:16];
   assign wr_timeout = item.slot_entry[15:0];

   // Stage B: stamp on a heartbeat, expire on a tick.
   assign hit = pb_vld_ff && (item.kind == REQ_HEARTBEAT) && (pb_slot_ff.node == item.node_id);
   assign expire = pb_vld_ff && (item.kind == REQ_TICK) && (item.nmt != NMT_INIT)
                   && (pb_slot_ff.node != 8'd0) && (pb_slot_ff.node <= MAX_CHECKED_NODE)
                   && pb_slot_ff.alive && (pb_elapsed_ff >= pb_limit_ff);

   always_comb begin
      pb_new = pb_slot_ff;
      if (hit) begin
         pb_new.last_seen_us = item.now_us;
         pb_new.alive        = 1'b1;
      end
      if (expire) begin
         pb_new.alive = 1'b0;
      end
   end

   // Scan results gathered over the pass.
   always_comb begin
      dup_in  = dup_ff;
      capt_in = capt_ff;
      mask_in = mask_ff;
      err_in  = err_ff;
      if (start) begin
         dup_in  = 1'b0;
         capt_in = '0;
         mask_in = '0;
         err_in  = 1'b0;
      end else begin
         if (pb_vld_ff && (item.kind == REQ_SLOT_WRITE) && (wr_node != 8'd0)
             && (pb_idx8 != s8) && (pb_slot_ff.node == wr_node)) begin
            dup_in = 1'b1;
         end
         if (pb_vld_ff && (pb_idx8 == s8)) begin
            capt_in = pb_slot_ff;
         end
         if (expire) begin
            err_in = 1'b1;
            if (pb_idx8 < 8'(MASK_W)) begin
               mask_in[pb_idx8[2:0]] = 1'b1;
            end
         end
      end
   end

   // The slot write of a request and the scan write-back never coincide.
   always_comb begin
      priority if (commit) begin
         we    = 1'b1;
         waddr = s8[IW-1:0];
         wdata = '{node: wr_node, timeout_ms: wr_timeout,
                   last_seen_us: capt_ff.last_seen_us, alive: capt_ff.alive};
      end else begin
         we    = hit || expire;
         waddr = pb_idx_ff;
         wdata = pb_new;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      dup_ff  <= dup_in;
      capt_ff <= capt_in;
      mask_ff <= mask_in;
      err_ff  <= err_in;
   end

   assign stat.dup          = dup_ff;
   assign stat.idle         = !pa_vld_ff && !pb_vld_ff;
   assign stat.mask         = mask_ff;
   assign stat.err          = err_ff;
   assign stat.capt_node    = capt_ff.node;
   assign stat.capt_timeout = capt_ff.timeout_ms;
   assign stat.clr_valid    = expire;
   assign stat.clr_node     = pb_slot_ff.node;

endmodule

// File: design/heartbeat_producer_consumer_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_stall   request type, node, time, state, slot, entry
// rsp_      out        rsp_valid/rsp_stall   status, heartbeat frame, expiry, read, presence
// csr_      in         APB-style, pready=1   producer period, own node id
//
// From acceptance to the next acceptance an item passes through one read of the slot
// memory per slot, a drain of the two-stage write-back, a commit step, a presence read,
// a result cycle and the idle cycle that accepts the next word. A tick in init state goes
// straight to the presence read. Reset clears valid bits at once, no clearing pass.
// The next word is accepted while a result still waits; the result cycle waits
// only if the previous result has not been taken.
module heartbeat_producer_consumer_unit #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [7:0]                      req_node_id,
   input  logic [31:0]                     req_now_us,
   input  logic [1:0]                      req_nmt_state,
   input  logic [7:0]                      req_slot_index,
   input  logic [23:0]                     req_slot_entry,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_send_heartbeat,
   output logic [10:0]                     rsp_heartbeat_can_id,
   output logic [6:0]                      rsp_heartbeat_state_code,
   output logic [7:0]                      rsp_expired_mask,
   output logic                            rsp_comm_error,
   output logic [23:0]                     rsp_read_entry,
   output logic                            rsp_node_present,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hpcu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   import hpcu_pkg::*;

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   cfg_type       cfg;
   slot_stat_type stat;
   fsm_type       state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   item_type      item_ff;
   logic [31:0]   prod_last_ff;
   logic [31:0]   prod_elapsed_ff;
   logic [31:0]   prod_limit_ff;
   logic          send_ff, send_in;
   logic [255:0]  pres_vld_ff, pres_vld_in;
   logic          pres_vq_ff;
   logic [0:0]    pres_q;
   logic          pres_we;
   logic [7:0]    pres_waddr;
   logic [0:0]    pres_wdata;
   logic          accept;
   logic          start;
   logic          issue;
   logic          commit;
   logic          load_rsp;
   logic          idx_good;
   logic          tick_init;
   logic          rsp_valid_ff;
   status_type    status_in;
   logic [1:0]    status_ff;
   logic          send_out_ff;
   logic [10:0]   can_id_ff;
   logic [6:0]    code_ff;
   logic [7:0]    mask_ff;
   logic          err_ff;
   logic [23:0]   read_ff;
   logic          present_ff;

   hpcu_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (csr_psel),
      .penable(csr_penable),
      .pwrite (csr_pwrite),
      .paddr  (csr_paddr),
      .pwdata (csr_pwdata),
      .prdata (csr_prdata),
      .pready (csr_pready),
      .cfg    (cfg)
   );

   hpcu_slot_pipe #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_slot_pipe (
      .clock    (clock),
      .reset    (reset),
      .item     (item_ff),
      .start    (start),
      .issue    (issue),
      .issue_idx(cnt_ff),
      .commit   (commit),
      .stat     (stat)
   );

   // Presence map: set by a received heartbeat, cleared by an expiry.
   hpcu_ram #(
      .WIDTH(1),
      .DEPTH(256)
   ) u_pres_ram (
      .clock(clock),
      .we   (pres_we),
      .waddr(pres_waddr),
      .wdata(pres_wdata),
      .raddr(item_ff.node_id),
      .rdata(pres_q)
   );

   assign req_stall = reset || (state_ff != FSM_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      priority if (accept && (req_kind_type'(req_type) == REQ_HEARTBEAT)) begin
         pres_we    = 1'b1;
         pres_waddr = req_node_id;
         pres_wdata = 1'b1;
      end else begin
         pres_we    = stat.clr_valid;
         pres_waddr = stat.clr_node;
         pres_wdata = 1'b0;
      end
   end

   always_comb begin
      pres_vld_in = pres_vld_ff;
      if (pres_we) begin
         pres_vld_in[pres_waddr] = 1'b1;
      end
   end

   assign idx_good  = (item_ff.slot_index != 8'd0) && (item_ff.slot_index <= 8'(NUM_SLOTS));
   assign tick_init = (item_ff.kind == REQ_TICK) && (item_ff.nmt == NMT_INIT);

   // Sequencer: next state and strobes.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      send_in  = send_ff;
      start    = 1'b0;
      issue    = 1'b0;
      commit   = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               start   = 1'b1;
               cnt_in  = '0;
               send_in = 1'b0;
               if ((req_kind_type'(req_type) == REQ_TICK)
                   && (nmt_type'(req_nmt_state) == NMT_INIT)) begin
                  state_in = FSM_PRES;
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end
         FSM_SCAN: begin
            issue = 1'b1;
            if (cnt_ff == IW'(NUM_SLOTS - 1)) begin
               state_in = FSM_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         FSM_DRAIN: begin
            if (stat.idle) begin
               state_in = FSM_COMMIT;
            end
         end
         FSM_COMMIT: begin
            commit   = (item_ff.kind == REQ_SLOT_WRITE) && idx_good && !stat.dup;
            send_in  = (item_ff.kind == REQ_TICK) && (item_ff.nmt != NMT_INIT)
                       && (cfg.period_ms != 16'd0) && (prod_elapsed_ff >= prod_limit_ff);
            state_in = FSM_PRES;
         end
         FSM_PRES: begin
            state_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         prod_last_ff <= '0;
         pres_vld_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         pres_vld_ff <= pres_vld_in;
         if ((state_ff == FSM_COMMIT) && send_in) begin
            prod_last_ff <= item_ff.now_us;
         end
      end
      cnt_ff     <= cnt_in;
      send_ff    <= send_in;
      pres_vq_ff <= pres_vld_ff[item_ff.node_id];
      if (accept) begin
         item_ff.kind       <= req_kind_type'(req_type);
         item_ff.node_id    <= req_node_id;
         item_ff.now_us     <= req_now_us;
         item_ff.nmt        <= nmt_type'(req_nmt_state);
         item_ff.slot_index <= req_slot_index;
         item_ff.slot_entry <= req_slot_entry;
         prod_elapsed_ff    <= req_now_us - prod_last_ff;
         prod_limit_ff      <= ms_to_us(cfg.period_ms);
      end
   end

   // Status code of the finished request.
   always_comb begin
      priority if (tick_init) begin
         status_in = ST_TICK_INIT;
      end else if ((item_ff.kind == REQ_SLOT_WRITE || item_ff.kind == REQ_SLOT_READ)
                   && !idx_good) begin
         status_in = ST_BAD_INDEX;
      end else if ((item_ff.kind == REQ_SLOT_WRITE) && stat.dup) begin
         status_in = ST_DUPLICATE;
      end else begin
         status_in = ST_OK;
      end
   end

   // Output register: holds the word until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         status_ff   <= status_in;
         send_out_ff <= send_ff;
         can_id_ff   <= send_ff ? (HB_BASE_ID + 11'(cfg.own_id)) : 11'd0;
         code_ff     <= send_ff ? state_code(item_ff.nmt) : CODE_NONE;
         mask_ff     <= stat.mask;
         err_ff      <= stat.err;
         read_ff     <= ((item_ff.kind == REQ_SLOT_READ) && idx_good)
                        ? {stat.capt_node, stat.capt_timeout} : 24'd0;
         present_ff  <= pres_vq_ff && pres_q[0];
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = status_ff;
   assign rsp_send_heartbeat       = send_out_ff;
   assign rsp_heartbeat_can_id     = can_id_ff;
   assign rsp_heartbeat_state_code = code_ff;
   assign rsp_expired_mask         = mask_ff;
   assign rsp_comm_error           = err_ff;
   assign rsp_read_entry           = read_ff;
   assign rsp_node_present         = present_ff;

endmodule

// File: design/hpcu_checker.sv
`timescale 1ns / 1ps

`include "heartbeat_producer_consumer_unit_assert.svh"

module hpcu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_send_heartbeat,
   input logic [10:0] rsp_heartbeat_can_id,
   input logic [6:0]  rsp_heartbeat_state_code,
   input logic [7:0]  rsp_expired_mask,
   input logic        rsp_comm_error,
   input logic [23:0] rsp_read_entry,
   input logic        rsp_node_present
);

   import hpcu_pkg::*;

   // A stalled result word holds.
   `HPCU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_read_entry) && $stable(rsp_node_present) && $stable(rsp_expired_mask))

   // One request at a time: an accepted word blocks the input next cycle.
   `HPCU_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)

   // Frame fields are zero unless a frame is sent.
   `HPCU_ASSERT_SAME(a_no_frame, clock, reset, rsp_valid && !rsp_send_heartbeat, rsp_heartbeat_can_id == 11'd0 && rsp_heartbeat_state_code == 7'd0)

   // A sent frame carries a heartbeat identifier and comes from a good tick.
   `HPCU_ASSERT_SAME(a_frame_id, clock, reset, rsp_valid && rsp_send_heartbeat, rsp_heartbeat_can_id[10:7] == 4'b1110 && rsp_status == ST_OK)

   // An expiry bit implies the error flag.
   `HPCU_ASSERT_SAME(a_mask_err, clock, reset, rsp_valid && !rsp_comm_error, rsp_expired_mask == 8'd0)

endmodule

bind heartbeat_producer_consumer_unit hpcu_checker u_checker (.*);
